// ===== design/pvs_pkg.sv =====
// ----------------------------------------------------------------------------
// pvs_pkg
// Shared widths, codes and the page entry layout of the page victim selector.
// ----------------------------------------------------------------------------
package pvs_pkg;

    localparam int PAGE_COUNT = 1024;
    localparam int PAGE_W     = $clog2(PAGE_COUNT);
    localparam int CNT_W      = $clog2(PAGE_COUNT + 1);
    localparam int INDEX_W    = 10;
    localparam int TIME_W     = 64;
    localparam int COUNT_W    = 32;
    localparam int MODE_W     = 2;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    // eviction policy codes
    localparam logic [MODE_W-1:0] MODE_LRU  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LFU  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FIFO = 2'd2;

    // command codes
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SELECT = 1'b1;

    // register index of eviction_mode
    localparam logic REG_MODE = 1'b0;

    typedef logic [MODE_W-1:0] t_mode;

    typedef struct packed {
        logic               resident;
        logic               locked;
        logic [TIME_W-1:0]  access_time;
        logic [COUNT_W-1:0] access_total;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// ===== design/page_victim_selector.sv =====
// ----------------------------------------------------------------------------
// page_victim_selector
// Page table with LRU, LFU and round-robin FIFO victim selection.
// ----------------------------------------------------------------------------
//
//   channel | handshake                    | payload
//   --------+------------------------------+---------------------------------
//   in      | i_in_valid / o_in_stall      | command, page_index, resident,
//           |                              | locked, access_time, access_total
//   out     | o_out_valid / i_out_stall    | victim_found, victim_index
//   cfg     | psel penable pwrite pready   | paddr, pwdata, prdata
//
// A write command writes the entry into the page RAM at the accepting edge
// and gives no item on the output.
// A select command runs from its accepting edge to the next accept: the
// accepting cycle, a scan that reads the page RAM through its single read
// port, one entry a cycle, the read latency of the RAM, and the load of the
// output register, which waits while a stalled result still holds it.
// After reset a clearing pass writes every entry to zero with o_in_stall
// high; configuration writes are taken throughout.
// A finished result waits in the output register; new items (writes, and the
// start of the next select) are taken meanwhile, and a select that finishes
// while the output is still stalled holds until it is taken.
// ----------------------------------------------------------------------------
module page_victim_selector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    // input items
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_command,
    input  logic [pvs_pkg::INDEX_W-1:0]   i_page_index,
    input  logic                          i_resident,
    input  logic                          i_locked,
    input  logic [pvs_pkg::TIME_W-1:0]    i_access_time,
    input  logic [pvs_pkg::COUNT_W-1:0]   i_access_total,

    // result items
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_victim_found,
    output logic [pvs_pkg::INDEX_W-1:0]   o_victim_index,

    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pvs_pkg::ADDR_W-1:0]    paddr,
    input  logic [pvs_pkg::DATA_W-1:0]    pwdata,
    output logic [pvs_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    import pvs_pkg::*;

    localparam int ST_W = 2;
    localparam logic [ST_W-1:0] ST_CLEAR = 2'd0;
    localparam logic [ST_W-1:0] ST_IDLE  = 2'd1;
    localparam logic [ST_W-1:0] ST_SCAN  = 2'd2;
    localparam logic [ST_W-1:0] ST_DONE  = 2'd3;

    localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(PAGE_COUNT - 1);
    localparam logic [CNT_W-1:0]  SCAN_LEN  = CNT_W'(PAGE_COUNT);
    localparam logic [CNT_W-1:0]  SCAN_LAST = CNT_W'(PAGE_COUNT - 1);

    // ---------------------------------------------------------------- state
    logic [ST_W-1:0]    r_state,    n_state;
    logic [PAGE_W-1:0]  r_addr,     n_addr;      // clear / scan read address
    logic [CNT_W-1:0]   r_issued,   n_issued;    // reads issued in this scan
    logic               r_rd_vld,   n_rd_vld;    // RAM data valid next cycle
    logic               r_rd_last,  n_rd_last;
    logic [PAGE_W-1:0]  r_rd_idx,   n_rd_idx;
    t_mode              r_scan_mode, n_scan_mode;
    logic               r_found,    n_found;
    logic [PAGE_W-1:0]  r_best_idx, n_best_idx;
    logic [TIME_W-1:0]  r_best_key, n_best_key;
    logic [PAGE_W-1:0]  r_cursor,   n_cursor;
    t_mode              r_mode,     n_mode;
    logic               r_out_vld,  n_out_vld;
    logic               r_out_found, n_out_found;
    logic [PAGE_W-1:0]  r_out_idx,  n_out_idx;

    // ---------------------------------------------------------------- RAM
    logic               ram_we;
    logic [PAGE_W-1:0]  ram_waddr;
    t_entry             ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry             rd_entry;

    pvs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PAGE_COUNT)
    ) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign rd_entry = t_entry'(ram_rdata);

    // ---------------------------------------------------------------- input
    logic in_acc;
    logic wr_in_range;
    logic cfg_wr;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    // writes beyond the table are dropped
    assign wr_in_range = ({{(32 - INDEX_W){1'b0}}, i_page_index} < 32'(PAGE_COUNT));

    assign cfg_wr = psel && penable && pwrite && pready;

    // ---------------------------------------------------------------- scan
    logic              is_cand;
    logic [TIME_W-1:0] cur_key;
    logic              take;
    logic              out_free;
    logic              lfu_scan;

    assign lfu_scan = (r_scan_mode == MODE_LFU);
    assign is_cand  = rd_entry.resident && !rd_entry.locked;
    // LFU keys are zero-extended to the time width; the start value follows
    assign cur_key  = lfu_scan ? TIME_W'(rd_entry.access_total) : rd_entry.access_time;
    assign out_free = !r_out_vld || !i_out_stall;

    always_comb begin
        take = 1'b0;
        if (r_rd_vld && is_cand) begin
            if (r_scan_mode == MODE_FIFO) begin
                take = !r_found;
            end else begin
                take = (cur_key < r_best_key);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_issued    = r_issued;
        n_rd_vld    = 1'b0;
        n_rd_last   = 1'b0;
        n_rd_idx    = r_addr;
        n_scan_mode = r_scan_mode;
        n_found     = r_found;
        n_best_idx  = r_best_idx;
        n_best_key  = r_best_key;
        n_cursor    = r_cursor;
        n_mode      = r_mode;
        n_out_vld   = r_out_vld;
        n_out_found = r_out_found;
        n_out_idx   = r_out_idx;

        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = '0;

        if (cfg_wr && (paddr[2] == REG_MODE)) begin
            n_mode = pwdata[MODE_W-1:0];
        end

        // drain the output register
        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                // zero every entry so no page is resident after reset
                ram_we = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == LAST_PAGE) begin
                    n_addr  = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_command == CMD_WRITE) begin
                        ram_we    = wr_in_range;
                        ram_waddr = PAGE_W'({{(32 - INDEX_W){1'b0}}, i_page_index});
                        ram_wdata.resident     = i_resident;
                        ram_wdata.locked       = i_locked;
                        ram_wdata.access_time  = i_access_time;
                        ram_wdata.access_total = i_access_total;
                    end else begin
                        n_state     = ST_SCAN;
                        n_scan_mode = r_mode;
                        n_issued    = '0;
                        n_found     = 1'b0;
                        n_best_idx  = '0;
                        n_addr      = (r_mode == MODE_FIFO) ? r_cursor : '0;
                        n_best_key  = (r_mode == MODE_LFU) ?
                                      TIME_W'({COUNT_W{1'b1}}) : {TIME_W{1'b1}};
                    end
                end
            end
            ST_SCAN: begin
                // issue one read per cycle, wrapping at the end of the table
                if (r_issued < SCAN_LEN) begin
                    n_rd_vld  = 1'b1;
                    n_rd_last = (r_issued == SCAN_LAST);
                    n_rd_idx  = r_addr;
                    n_issued  = r_issued + 1'b1;
                    n_addr    = (r_addr == LAST_PAGE) ? '0 : r_addr + 1'b1;
                end
                if (take) begin
                    n_found    = 1'b1;
                    n_best_idx = r_rd_idx;
                    n_best_key = cur_key;
                end
                if (r_rd_vld && r_rd_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register can take the result
                if (out_free) begin
                    n_out_vld   = 1'b1;
                    n_out_found = r_found;
                    n_out_idx   = r_found ? r_best_idx : '0;
                    if (r_found && (r_scan_mode == MODE_FIFO)) begin
                        n_cursor = (r_best_idx == LAST_PAGE) ? '0 : r_best_idx + 1'b1;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_addr    <= '0;
            r_issued  <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
            r_found   <= 1'b0;
            r_cursor  <= '0;
            r_mode    <= MODE_LRU;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_issued  <= n_issued;
            r_rd_vld  <= n_rd_vld;
            r_rd_last <= n_rd_last;
            r_found   <= n_found;
            r_cursor  <= n_cursor;
            r_mode    <= n_mode;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx    <= n_rd_idx;
        r_scan_mode <= n_scan_mode;
        r_best_idx  <= n_best_idx;
        r_best_key  <= n_best_key;
        r_out_found <= n_out_found;
        r_out_idx   <= n_out_idx;
    end

    // ---------------------------------------------------------------- outputs
    assign o_out_valid    = r_out_vld;
    assign o_victim_found = r_out_found;
    assign o_victim_index = INDEX_W'({{(32 - PAGE_W){1'b0}}, r_out_idx});

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MODE) ? DATA_W'(r_mode) : '0;

endmodule

// ===== design/pvs_ram.sv =====
// ----------------------------------------------------------------------------
// pvs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/pvs_checker.sv =====
// ----------------------------------------------------------------------------
// pvs_checker
// Port-level checks of the page victim selector, bound to the top level.
// ----------------------------------------------------------------------------
module pvs_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_stall,
    input  logic                          i_command,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  logic                          o_victim_found,
    input  logic [pvs_pkg::INDEX_W-1:0]   o_victim_index
);

    import pvs_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_victim_found) && $stable(o_victim_index))
        else $error("stalled result changed");

    // no victim means index zero
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_victim_found |-> o_victim_index == '0)
        else $error("victim index not zero without a victim");

    // a select occupies the block for its scan
    a_select_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_command == CMD_SELECT) |=> o_in_stall)
        else $error("input taken right after a select");

    // a new result frees the input side at once
    a_result_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_stall)
        else $error("input still stalled after a result was loaded");

endmodule

bind page_victim_selector pvs_checker u_pvs_checker (.*);

// ===== verif/tb_page_victim_selector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_page_victim_selector
// Self-checking bench for the page victim selector. Directed tests hit the
// empty table, all-ones keys, locked and absent pages, ties, the spare mode
// code, cursor wrap and the unused register address. Random phases then mix
// page writes, victim selects and evict-or-refill follow-ups under every
// policy. Each select is predicted at acceptance and checked in order.
// ----------------------------------------------------------------------------
module tb_page_victim_selector;

    import pvs_pkg::*;

    // Spare policy code: the block treats it as LRU.
    localparam t_mode MODE_SPARE    = 2'd3;
    // First register index past the list: writes to it must have no effect.
    localparam int    REG_UNUSED    = 1;
    // Idle wait after draining, so a trailing write retires before the mode changes.
    localparam int    SETTLE_CYCLES = 8;
    // After the last result, watch a full scan for stray output items.
    localparam int    END_CYCLES    = PAGE_COUNT + 16;
    // Worst case is far below this: every item a select, with stalls and
    // gaps, plus the clearing pass after reset.
    localparam int    MAX_CYCLES    = 4_000_000;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] index;
    } t_victim;

    typedef enum int {STALL_NONE, STALL_SCATTER, STALL_LONG} t_stall_pat;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT ports
    // ------------------------------------------------------------------------
    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;

    logic                 in_valid      = 1'b0;
    logic                 in_stall;
    logic                 in_command    = CMD_WRITE;
    logic [INDEX_W-1:0]   in_page_index = '0;
    logic                 in_resident   = 1'b0;
    logic                 in_locked     = 1'b0;
    logic [TIME_W-1:0]    in_stamp      = '0;
    logic [COUNT_W-1:0]   in_hits       = '0;

    logic                 out_valid;
    logic                 out_stall     = 1'b0;
    logic                 out_found;
    logic [INDEX_W-1:0]   out_index;

    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [ADDR_W-1:0]    paddr         = '0;
    logic [DATA_W-1:0]    pwdata        = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    page_victim_selector i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_command      (in_command),
        .i_page_index   (in_page_index),
        .i_resident     (in_resident),
        .i_locked       (in_locked),
        .i_access_time  (in_stamp),
        .i_access_total (in_hits),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_victim_found (out_found),
        .o_victim_index (out_index),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // ------------------------------------------------------------------------
    // Page table shadow: what the block should hold after every accepted item
    // ------------------------------------------------------------------------
    logic                 page_resident [PAGE_COUNT];
    logic                 page_locked   [PAGE_COUNT];
    logic [TIME_W-1:0]    page_stamp    [PAGE_COUNT];
    logic [COUNT_W-1:0]   page_hits     [PAGE_COUNT];
    int                   rr_cursor = 0;
    t_mode                policy    = MODE_LRU;

    // Victims predicted at acceptance, oldest first.
    t_victim              pending_victims [$];
    t_victim              last_victim = '0;

    int                   mismatches  = 0;
    int                   num_writes  = 0;
    int                   num_selects = 0;
    int                   num_found   = 0;
    int                   cycle_count = 0;

    // Sender pacing: bursts of items separated by idle gaps.
    bit                   pace_on    = 1'b0;
    int                   burst_left = 0;
    logic [INDEX_W-1:0]   hot_base   = '0;

    // Pick a victim the way the block should, and advance the FIFO cursor.
    function automatic t_victim choose_victim();
        t_victim            v;
        logic [TIME_W-1:0]  best_stamp;
        logic [COUNT_W-1:0] best_hits;
        int                 slot;
        v          = '0;
        best_stamp = '1;
        best_hits  = '1;
        case (policy)
            MODE_LFU: begin
                // Strict less-than: lowest index wins a tie, all-ones never wins.
                for (int i = 0; i < PAGE_COUNT; i++) begin
                    if (page_resident[i] && !page_locked[i] && page_hits[i] < best_hits) begin
                        best_hits = page_hits[i];
                        v.found   = 1'b1;
                        v.index   = INDEX_W'(i);
                    end
                end
            end
            MODE_FIFO: begin
                // Scan round-robin from the cursor; park it just past the victim.
                for (int k = 0; k < PAGE_COUNT && !v.found; k++) begin
                    slot = (rr_cursor + k) % PAGE_COUNT;
                    if (page_resident[slot] && !page_locked[slot]) begin
                        v.found   = 1'b1;
                        v.index   = INDEX_W'(slot);
                        rr_cursor = (slot + 1) % PAGE_COUNT;
                    end
                end
            end
            default: begin
                // LRU, and the spare code falls here too.
                for (int i = 0; i < PAGE_COUNT; i++) begin
                    if (page_resident[i] && !page_locked[i] && page_stamp[i] < best_stamp) begin
                        best_stamp = page_stamp[i];
                        v.found    = 1'b1;
                        v.index    = INDEX_W'(i);
                    end
                end
            end
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: compare every output item taken with the oldest victim
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_victim want;
        if (i_rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
            if (pending_victims.size() == 0) begin
                $display("%0t: unexpected result item, expected none, actual found %0b index %0d",
                         $time, out_found, out_index);
                mismatches++;
            end else begin
                want = pending_victims.pop_front();
                if (out_found !== want.found) begin
                    $display("%0t: victim_found mismatch, expected %0b, actual %0b",
                             $time, want.found, out_found);
                    mismatches++;
                end
                if (out_index !== want.index) begin
                    $display("%0t: victim_index mismatch, expected %0d, actual %0d",
                             $time, want.index, out_index);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver stall: switch between no stall, scattered stalls and long holds
    // ------------------------------------------------------------------------
    t_stall_pat stall_pat        = STALL_NONE;
    int         stall_phase_left = 0;
    int         stall_hold       = 0;

    always @(negedge i_clk) begin
        logic next_stall;
        if (stall_phase_left == 0) begin
            stall_pat        = t_stall_pat'($urandom_range(0, 2));
            stall_phase_left = $urandom_range(100, 400);
        end else begin
            stall_phase_left--;
        end
        case (stall_pat)
            STALL_NONE:    next_stall = 1'b0;
            STALL_SCATTER: next_stall = ($urandom_range(0, 3) == 0);
            default: begin
                // Hold the current level for a while, then flip it.
                if (stall_hold == 0) begin
                    next_stall = !out_stall;
                    stall_hold = $urandom_range(1, 60);
                end else begin
                    next_stall = out_stall;
                    stall_hold--;
                end
            end
        endcase
        out_stall <= next_stall;
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, pending_victims.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Present one item, hold it until taken, then record its effect.
    // Valid stays high on return unless a paced burst ended: the caller either
    // sends again or drops it at the next falling edge.
    task automatic send_item(input logic               cmd,
                             input logic [INDEX_W-1:0] idx,
                             input logic               res,
                             input logic               lock,
                             input logic [TIME_W-1:0]  stamp,
                             input logic [COUNT_W-1:0] hits);
        int gap;
        @(negedge i_clk);
        in_valid      <= 1'b1;
        in_command    <= cmd;
        in_page_index <= idx;
        in_resident   <= res;
        in_locked     <= lock;
        in_stamp      <= stamp;
        in_hits       <= hits;
        do @(posedge i_clk); while (in_stall !== 1'b0);
        if (cmd == CMD_WRITE) begin
            page_resident[idx] = res;
            page_locked[idx]   = lock;
            page_stamp[idx]    = stamp;
            page_hits[idx]     = hits;
            num_writes++;
        end else begin
            last_victim = choose_victim();
            pending_victims.push_back(last_victim);
            num_selects++;
            if (last_victim.found)
                num_found++;
        end
        // End of burst: drop valid for a random gap and start a new burst.
        if (pace_on) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 23);
                gap        = $urandom_range(1, 10);
                @(negedge i_clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    task automatic write_page(input logic [INDEX_W-1:0] idx,
                              input logic               res,
                              input logic               lock,
                              input logic [TIME_W-1:0]  stamp,
                              input logic [COUNT_W-1:0] hits);
        send_item(CMD_WRITE, idx, res, lock, stamp, hits);
    endtask

    // The other fields are don't-care on a select; fill them with noise.
    task automatic select_victim();
        send_item(CMD_SELECT, INDEX_W'($urandom), 1'($urandom), 1'($urandom),
                  {$urandom, $urandom}, $urandom);
    endtask

    // Drop valid and wait until every predicted victim has come out.
    task automatic wait_drained();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_victims.size() != 0) @(negedge i_clk);
    endtask

    // Drain, then let a trailing write item retire before the mode changes.
    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // One register access: setup cycle, then access cycle until pready.
    task automatic reg_access(input  bit                is_write,
                              input  int                reg_idx,
                              input  logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= ADDR_W'(4 * reg_idx);
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        if (is_write && reg_idx == REG_MODE)
            policy = wdata[MODE_W-1:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Switch policy while idle and read it back.
    task automatic set_policy(input t_mode mode);
        logic [DATA_W-1:0] rdata;
        settle();
        reg_access(1'b1, REG_MODE, DATA_W'(mode), rdata);
        reg_access(1'b0, REG_MODE, '0, rdata);
        if (rdata !== DATA_W'(policy)) begin
            $display("%0t: eviction_mode readback mismatch, expected %0d, actual %0d",
                     $time, policy, rdata);
            mismatches++;
        end
    endtask

    // Keys lean on ties, zero and values at or next to all-ones.
    function automatic logic [TIME_W-1:0] rand_key();
        logic [TIME_W-1:0] k;
        case ($urandom_range(0, 9))
            0:       k = '1;
            1:       k = '0;
            2, 3, 4: k = TIME_W'($urandom_range(0, 7));
            5:       k = '1 - TIME_W'($urandom_range(1, 3));
            default: k = {$urandom, $urandom};
        endcase
        return k;
    endfunction

    // Pages cluster around a hot window so that entries get rewritten.
    function automatic logic [INDEX_W-1:0] rand_page();
        logic [INDEX_W-1:0] p;
        case ($urandom_range(0, 9))
            0:          p = '0;
            1:          p = '1;
            2, 3, 4, 5: p = hot_base + INDEX_W'($urandom_range(0, 15));
            default:    p = INDEX_W'($urandom_range(0, PAGE_COUNT - 1));
        endcase
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Nothing resident yet: no victim, index zero.
    task automatic test_empty_table();
        set_policy(MODE_LRU);
        select_victim();
    endtask

    // LRU skips locked and absent pages and never takes an all-ones time.
    task automatic test_lru_keys();
        write_page('0, 1'b1, 1'b0, '1, '0);
        write_page('1, 1'b1, 1'b0, '0, '1);
        write_page(INDEX_W'(5), 1'b1, 1'b1, '0, '0);
        write_page(INDEX_W'(7), 1'b0, 1'b0, '0, '0);
        select_victim();
        write_page('1, 1'b1, 1'b0, '1, '1);
        select_victim();
    endtask

    // LFU takes the zero count, then finds nothing once all counts are all-ones.
    task automatic test_lfu_keys();
        set_policy(MODE_LFU);
        select_victim();
        write_page('0, 1'b1, 1'b0, '1, '1);
        select_victim();
    endtask

    // Spare code acts as LRU; equal times go to the lower index.
    task automatic test_spare_mode();
        set_policy(MODE_SPARE);
        write_page(INDEX_W'(512), 1'b1, 1'b0, TIME_W'(5), COUNT_W'(9));
        write_page(INDEX_W'(300), 1'b1, 1'b0, TIME_W'(5), COUNT_W'(9));
        select_victim();
    endtask

    // Walk the cursor across the table and wrap past the last page.
    task automatic test_fifo_wrap();
        set_policy(MODE_FIFO);
        repeat (5) select_victim();
    endtask

    // A write to the unused address must leave the policy alone.
    task automatic test_unused_register();
        logic [DATA_W-1:0] rdata;
        settle();
        reg_access(1'b1, REG_UNUSED, DATA_W'(MODE_LRU), rdata);
        select_victim();
    endtask

    // Random page traffic under one policy. Most selects that find a page are
    // followed by the usual reaction: evict the victim or refill its slot.
    task automatic test_random_policy(input t_mode mode, input int items, input bit paced);
        bit evict_next;
        set_policy(mode);
        pace_on    = paced;
        burst_left = 0;
        hot_base   = INDEX_W'($urandom_range(0, PAGE_COUNT - 1));
        evict_next = 1'b0;
        repeat (items) begin
            // Now and then hold off until every result is back.
            if ($urandom_range(0, 39) == 0)
                wait_drained();
            if (evict_next) begin
                if ($urandom_range(0, 1))
                    write_page(last_victim.index, 1'b0, 1'b0, rand_key(),
                               COUNT_W'(rand_key()));
                else
                    write_page(last_victim.index, 1'b1, $urandom_range(0, 7) == 0,
                               rand_key(), COUNT_W'(rand_key()));
                evict_next = 1'b0;
            end else if ($urandom_range(0, 99) < 78) begin
                write_page(rand_page(), $urandom_range(0, 9) < 7, $urandom_range(0, 4) == 0,
                           rand_key(), COUNT_W'(rand_key()));
            end else begin
                select_victim();
                evict_next = last_victim.found && $urandom_range(0, 9) < 6;
            end
        end
        pace_on = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        for (int i = 0; i < PAGE_COUNT; i++) begin
            page_resident[i] = 1'b0;
            page_locked[i]   = 1'b0;
            page_stamp[i]    = '0;
            page_hits[i]     = '0;
        end

        // Hold reset, then release it on a falling edge.
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_lru_keys();
        test_lfu_keys();
        test_spare_mode();
        test_fifo_wrap();
        test_unused_register();

        test_random_policy(MODE_LRU,   112, 1'b1);
        test_random_policy(MODE_LFU,   112, 1'b0);
        test_random_policy(MODE_FIFO,  112, 1'b1);
        test_random_policy(MODE_SPARE, 112, 1'b1);
        test_random_policy(MODE_FIFO,  112, 1'b0);

        // Let all results out, then watch a full scan for anything extra.
        wait_drained();
        repeat (END_CYCLES) @(posedge i_clk);

        $display("Covered %0d page writes and %0d victim selects (%0d found a page)",
                 num_writes, num_selects, num_found);
        $display("under LRU, LFU, FIFO and the spare mode code; %0d mismatches", mismatches);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/pvs_pkg.sv
design/pvs_ram.sv
design/page_victim_selector.sv
design/pvs_checker.sv
verif/tb_page_victim_selector.sv
